[src/segment_grid_cell_walker_defines.svh]
`ifndef SEGMENT_GRID_CELL_WALKER_DEFINES_SVH
`define SEGMENT_GRID_CELL_WALKER_DEFINES_SVH

// checks that hold in the cycle after the condition
`define SGW_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

// checks that hold in the same cycle as the condition
`define SGW_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

`endif

[src/sgw_pkg.sv]
package sgw_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;

  localparam int DW     = 33;  // coordinate difference
  localparam int AW     = 40;  // boundary numerator
  localparam int PW     = 74;  // cross product
  localparam int CHUNK  = 11;  // multiplier slice
  localparam int NCHUNK = 3;
  localparam int QBITS  = 7;   // saturation step plus six quotient bits

  localparam logic [5:0] RESULT_CAP = 6'd63;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_COLUMNS  = 3'd4;
  localparam logic [2:0] REG_ROWS     = 3'd5;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_TMUL,
    F_AXY,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_WALK
  } back_state_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [31:0]        w;
    logic [31:0]        h;
    logic [5:0]         ncol;
    logic [5:0]         nrow;
  } cfg_t;

  typedef struct packed {
    logic [4:0]           cx;
    logic [4:0]           cy;
    logic [4:0]           ex;
    logic [4:0]           ey;
    logic                 sxn;
    logic                 sxneg;
    logic                 syn;
    logic                 syneg;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] kx;
    logic signed [PW-1:0] ky;
  } job_t;

endpackage

[src/sgw_regs.sv]
module sgw_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output sgw_pkg::cfg_t cfg
);
  import sgw_pkg::*;

  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] cell_width;
  logic [31:0] cell_height;
  logic [5:0]  grid_columns;
  logic [5:0]  grid_rows;
  logic        wr_en;
  logic [2:0]  idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_width   <= 32'd65536;
      cell_height  <= 32'd65536;
      grid_columns <= 6'd32;
      grid_rows    <= 6'd32;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_X: origin_x     <= pwdata;
        REG_ORIGIN_Y: origin_y     <= pwdata;
        REG_WIDTH:    cell_width   <= pwdata;
        REG_HEIGHT:   cell_height  <= pwdata;
        REG_COLUMNS:  grid_columns <= pwdata[5:0];
        REG_ROWS:     grid_rows    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = origin_x;
      REG_ORIGIN_Y: prdata = origin_y;
      REG_WIDTH:    prdata = cell_width;
      REG_HEIGHT:   prdata = cell_height;
      REG_COLUMNS:  prdata = {26'd0, grid_columns};
      REG_ROWS:     prdata = {26'd0, grid_rows};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg.ox = $signed(origin_x);
    cfg.oy = $signed(origin_y);
    cfg.w  = (cell_width == '0) ? 32'd1 : cell_width;
    cfg.h  = (cell_height == '0) ? 32'd1 : cell_height;
    if (grid_columns == '0) begin
      cfg.ncol = 6'd1;
    end else if (grid_columns > 6'(MAX_COLUMNS)) begin
      cfg.ncol = 6'(MAX_COLUMNS);
    end else begin
      cfg.ncol = grid_columns;
    end
    if (grid_rows == '0) begin
      cfg.nrow = 6'd1;
    end else if (grid_rows > 6'(MAX_ROWS)) begin
      cfg.nrow = 6'(MAX_ROWS);
    end else begin
      cfg.nrow = grid_rows;
    end
  end

endmodule

[src/sgw_fifo.sv]
module sgw_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               pop,
  input  sgw_pkg::job_t      din,
  output sgw_pkg::job_t      dout,
  output logic               full,
  output logic               empty
);
  import sgw_pkg::*;

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

[src/sgw_front.sv]
module sgw_front (
  input  logic               clk,
  input  logic               rst,
  input  sgw_pkg::cfg_t      cfg,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic               full,
  output logic               push,
  output sgw_pkg::job_t      job
);
  import sgw_pkg::*;

  front_state_t         state;
  front_state_t         state_next;
  logic [2:0]           cnt;
  logic [DW-1:0]        num [4];
  logic [DW-1:0]        rem [4];
  logic [5:0]           q [4];
  logic [3:0]           sat;
  logic [3:0]           neg;
  logic [4:0]           cpos [4];
  logic [38:0]          dvw;
  logic [38:0]          dvh;
  logic [DW-1:0]        dxo_x;
  logic [DW-1:0]        dxo_y;
  logic [DW-1:0]        dx;
  logic [DW-1:0]        dy;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic [5:0]           mx;
  logic [5:0]           my;
  logic [37:0]          tx;
  logic [37:0]          ty;
  logic signed [AW-1:0] ax_c;
  logic signed [AW-1:0] ay_c;
  logic signed [AW-1:0] ma [4];
  logic [DW-1:0]        mb [4];
  logic signed [PW-1:0] acc [4];
  logic signed [AW+CHUNK:0] prod [4];

  assign num[0] = {start_x[31], start_x} - {cfg.ox[31], cfg.ox};
  assign num[1] = {start_y[31], start_y} - {cfg.oy[31], cfg.oy};
  assign num[2] = {end_x[31], end_x} - {cfg.ox[31], cfg.ox};
  assign num[3] = {end_y[31], end_y} - {cfg.oy[31], cfg.oy};

  assign adx = dx[DW-1] ? (DW'(0) - dx) : dx;
  assign ady = dy[DW-1] ? (DW'(0) - dy) : dy;

  // clamp of each cell coordinate into the grid
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [5:0] lim;
      lim = ((i % 2) == 0) ? (cfg.ncol - 6'd1) : (cfg.nrow - 6'd1);
      if (neg[i]) begin
        cpos[i] = '0;
      end else if (sat[i] || (q[i] > lim)) begin
        cpos[i] = lim[4:0];
      end else begin
        cpos[i] = q[i][4:0];
      end
    end
  end

  assign mx = dx[DW-1] ? {1'b0, cpos[0]} : ({1'b0, cpos[0]} + 6'd1);
  assign my = dy[DW-1] ? {1'b0, cpos[1]} : ({1'b0, cpos[1]} + 6'd1);

  always_comb begin
    logic signed [AW-1:0] tx_e;
    logic signed [AW-1:0] ty_e;
    logic signed [AW-1:0] ox_e;
    logic signed [AW-1:0] oy_e;
    tx_e = $signed({2'b00, tx});
    ty_e = $signed({2'b00, ty});
    ox_e = $signed({{(AW-DW){dxo_x[DW-1]}}, dxo_x});
    oy_e = $signed({{(AW-DW){dxo_y[DW-1]}}, dxo_y});
    ax_c = dx[DW-1] ? (ox_e - tx_e) : (tx_e - ox_e);
    ay_c = dy[DW-1] ? (oy_e - ty_e) : (ty_e - oy_e);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = ma[i] * $signed({1'b0, mb[i][CHUNK-1:0]});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (seg_valid) begin
        state_next = F_DIV;
      end
      F_DIV: if (cnt == 3'(QBITS - 1)) begin
        state_next = F_TMUL;
      end
      F_TMUL: state_next = F_AXY;
      F_AXY:  state_next = F_MUL;
      F_MUL: if (cnt == 3'(NCHUNK - 1)) begin
        state_next = F_PUSH;
      end
      F_PUSH: if (!full) begin
        state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    seg_ready = (state == F_IDLE);
    push      = (state == F_PUSH) && !full;
  end

  always_comb begin
    job.cx    = cpos[0];
    job.cy    = cpos[1];
    job.ex    = cpos[2];
    job.ey    = cpos[3];
    job.sxn   = (dx != '0);
    job.sxneg = dx[DW-1];
    job.syn   = (dy != '0);
    job.syneg = dy[DW-1];
    job.px    = acc[0];
    job.py    = acc[1];
    job.kx    = acc[2];
    job.ky    = acc[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        cnt   <= '0;
        dxo_x <= num[0];
        dxo_y <= num[1];
        dx    <= {end_x[31], end_x} - {start_x[31], start_x};
        dy    <= {end_y[31], end_y} - {start_y[31], start_y};
        dvw   <= {1'b0, cfg.w, 6'd0};
        dvh   <= {1'b0, cfg.h, 6'd0};
        for (int i = 0; i < 4; i++) begin
          rem[i] <= num[i];
          neg[i] <= num[i][DW-1];
          q[i]   <= '0;
          sat[i] <= 1'b0;
        end
      end
      F_DIV: begin
        for (int i = 0; i < 4; i++) begin
          logic [38:0] dv;
          logic        ge;
          dv = ((i % 2) == 0) ? dvw : dvh;
          ge = {6'd0, rem[i]} >= dv;
          if (cnt == '0) begin
            sat[i] <= ge;
          end else if (ge) begin
            rem[i] <= rem[i] - dv[DW-1:0];
            q[i]   <= {q[i][4:0], 1'b1};
          end else begin
            q[i]   <= {q[i][4:0], 1'b0};
          end
        end
        dvw <= dvw >> 1;
        dvh <= dvh >> 1;
        cnt <= (cnt == 3'(QBITS - 1)) ? '0 : cnt + 3'd1;
      end
      F_TMUL: begin
        tx <= {32'd0, mx} * {6'd0, cfg.w};
        ty <= {32'd0, my} * {6'd0, cfg.h};
      end
      F_AXY: begin
        cnt   <= '0;
        ma[0] <= ax_c;
        ma[1] <= ay_c;
        ma[2] <= $signed({8'd0, cfg.w});
        ma[3] <= $signed({8'd0, cfg.h});
        mb[0] <= ady;
        mb[1] <= adx;
        mb[2] <= ady;
        mb[3] <= adx;
        for (int i = 0; i < 4; i++) begin
          acc[i] <= '0;
        end
      end
      F_MUL: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] <= acc[i] + (PW'(prod[i]) <<< (CHUNK * int'(cnt)));
          mb[i]  <= mb[i] >> CHUNK;
        end
        cnt <= cnt + 3'd1;
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

[src/sgw_back.sv]
module sgw_back (
  input  logic          clk,
  input  logic          rst,
  input  sgw_pkg::cfg_t cfg,
  input  sgw_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  output logic          cell_valid,
  input  logic          cell_ready,
  output logic [4:0]    column,
  output logic [4:0]    row,
  output logic [9:0]    cell_index,
  output logic          last
);
  import sgw_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  logic [4:0]           cx;
  logic [4:0]           cy;
  logic [4:0]           ex;
  logic [4:0]           ey;
  logic                 sxn;
  logic                 sxneg;
  logic                 syn;
  logic                 syneg;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] kx;
  logic signed [PW-1:0] ky;
  logic [5:0]           cnt;
  logic                 advance;
  logic                 step_x;
  logic                 leave_x;
  logic                 leave_y;
  logic                 fin;
  logic [5:0]           ncol_m1;
  logic [5:0]           nrow_m1;
  logic [10:0]          idx_w;

  assign ncol_m1 = cfg.ncol - 6'd1;
  assign nrow_m1 = cfg.nrow - 6'd1;
  assign step_x  = sxn && (!syn || (px < py));
  assign leave_x = sxneg ? (cx == '0) : (cx == ncol_m1[4:0]);
  assign leave_y = !syn || (syneg ? (cy == '0) : (cy == nrow_m1[4:0]));
  assign fin     = ((cx == ex) && (cy == ey)) || (cnt == RESULT_CAP - 6'd1)
                   || (step_x ? leave_x : leave_y);
  assign idx_w   = ({6'd0, cy} * {5'd0, cfg.ncol}) + {6'd0, cx};

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!empty) begin
        state_next = B_WALK;
      end
      B_WALK: if (advance && fin) begin
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state == B_IDLE) && !empty;
    advance = (state == B_WALK) && (!cell_valid || cell_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      cell_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        cell_valid <= 1'b1;
      end else if (cell_ready) begin
        cell_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx    <= job.cx;
      cy    <= job.cy;
      ex    <= job.ex;
      ey    <= job.ey;
      sxn   <= job.sxn;
      sxneg <= job.sxneg;
      syn   <= job.syn;
      syneg <= job.syneg;
      px    <= job.px;
      py    <= job.py;
      kx    <= job.kx;
      ky    <= job.ky;
      cnt   <= '0;
    end else if (advance) begin
      column     <= cx;
      row        <= cy;
      cell_index <= idx_w[9:0];
      last       <= fin;
      cnt        <= cnt + 6'd1;
      if (!fin) begin
        if (step_x) begin
          cx <= sxneg ? (cx - 5'd1) : (cx + 5'd1);
          px <= px + kx;
        end else begin
          cy <= syneg ? (cy - 5'd1) : (cy + 5'd1);
          py <= py + ky;
        end
      end
    end
  end

endmodule

[src/segment_grid_cell_walker.sv]
// Segment grid walker: each segment item accepted on the seg channel yields,
// in walk order, one cell item per grid cell the segment crosses (at most 63),
// the final one flagged by last. A front end takes each segment, runs seven
// restoring-division steps that place both endpoints in the grid, two steps
// for the boundary offsets and three for the sliced cross products, then hands
// the job over, stalling while the queue is full; a two-entry job queue then
// feeds the walker, which loads a job and emits one cell per cycle while
// cell_ready is high. The front end can take a new segment while the walker
// still walks earlier ones. Configuration is written through the APB port; the
// user must write it only while no segment is in flight (the block does not enforce this).
module segment_grid_cell_walker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  output logic               cell_valid,
  input  logic               cell_ready,
  output logic [4:0]         column,
  output logic [4:0]         row,
  output logic [9:0]         cell_index,
  output logic               last
);
  import sgw_pkg::*;

  cfg_t cfg;
  job_t job_in;
  job_t job_out;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  assign pready = 1'b1;

  sgw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sgw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .full      (q_full),
    .push      (q_push),
    .job       (job_in)
  );

  sgw_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .din   (job_in),
    .dout  (job_out),
    .full  (q_full),
    .empty (q_empty)
  );

  sgw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job        (job_out),
    .empty      (q_empty),
    .pop        (q_pop),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .column     (column),
    .row        (row),
    .cell_index (cell_index),
    .last       (last)
  );

endmodule

[src/sgw_checker.sv]
`include "segment_grid_cell_walker_defines.svh"

module sgw_checker (
  input logic       clk,
  input logic       rst,
  input logic       seg_valid,
  input logic       seg_ready,
  input logic       cell_valid,
  input logic       cell_ready,
  input logic [9:0] cell_index,
  input logic       last
);

  `SGW_ASSERT_NEXT(a_cell_hold, cell_valid && !cell_ready, cell_valid, "cell item dropped")

  `SGW_ASSERT_NEXT(a_cell_stable, cell_valid && !cell_ready,
    $stable(cell_index) && $stable(last), "stalled cell item changed")

  `SGW_ASSERT_NEXT(a_front_busy, seg_valid && seg_ready, !seg_ready,
    "segment taken while set-up busy")

  `SGW_ASSERT_NEXT(a_walk_gapless, cell_valid && cell_ready && !last, cell_valid,
    "gap inside a segment walk")

  `SGW_ASSERT_NOW(a_last_known, cell_valid, !$isunknown(last), "last flag unknown")

endmodule

bind segment_grid_cell_walker sgw_checker u_sgw_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_valid  (seg_valid),
  .seg_ready  (seg_ready),
  .cell_valid (cell_valid),
  .cell_ready (cell_ready),
  .cell_index (cell_index),
  .last       (last)
);

[bench/segment_grid_cell_walker_checker.sv]
`timescale 1ns / 100ps

module segment_grid_cell_walker_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               seg_valid,
  input  logic               seg_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic               cell_valid,
  input  logic               cell_ready,
  input  logic [4:0]         column,
  input  logic [4:0]         row,
  input  logic [9:0]         cell_index,
  input  logic               last,
  output int                 fails,
  output int                 pending,
  output int                 segs_seen,
  output int                 cells_seen
);
  import sgw_pkg::*;

  typedef struct {
    logic [4:0] column;
    logic [4:0] row;
    logic [9:0] cell_index;
    logic       last;
  } cell_t;

  cell_t cell_q[$];

  logic signed [31:0] ox_r, oy_r;
  logic [31:0]        w_r, h_r;
  logic [5:0]         ncol_r, nrow_r;

  function automatic int cell_pos(longint d, longint size, int n);
    if (d < 0) return 0;
    if (d / size > n - 1) return n - 1;
    return int'(d / size);
  endfunction

  function automatic int eff_count(logic [5:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  task automatic plan_walk(input logic signed [31:0] px1, py1, px2, py2);
    longint x1, y1, x2, y2, ox, oy, w, h, dx, dy, ax, ay, adx, ady;
    int ncol, nrow, cx, cy, ex, ey, sx, sy, n;
    bit step_x;
    logic signed [127:0] a128, b128, c128, d128;
    cell_t c;
    x1 = px1; y1 = py1; x2 = px2; y2 = py2;
    ox = ox_r; oy = oy_r;
    w = (w_r == 0) ? 1 : longint'(w_r);
    h = (h_r == 0) ? 1 : longint'(h_r);
    ncol = eff_count(ncol_r, MAX_COLUMNS);
    nrow = eff_count(nrow_r, MAX_ROWS);
    cx = cell_pos(x1 - ox, w, ncol);
    cy = cell_pos(y1 - oy, h, nrow);
    ex = cell_pos(x2 - ox, w, ncol);
    ey = cell_pos(y2 - oy, h, nrow);
    dx = x2 - x1; dy = y2 - y1;
    sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
    sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    ax = 0; ay = 0; n = 0;
    if (sx > 0) ax = longint'(cx + 1) * w + ox - x1;
    else if (sx < 0) ax = x1 - (longint'(cx) * w + ox);
    if (sy > 0) ay = longint'(cy + 1) * h + oy - y1;
    else if (sy < 0) ay = y1 - (longint'(cy) * h + oy);
    forever begin
      c.column = cx[4:0];
      c.row = cy[4:0];
      c.cell_index = 10'(cy * ncol + cx);
      c.last = 1'b0;
      cell_q.insert(cell_q.size(), c);
      n++;
      if ((cx == ex && cy == ey) || n >= int'(RESULT_CAP)) break;
      if (sx == 0) step_x = 1'b0;
      else if (sy == 0) step_x = 1'b1;
      else begin
        a128 = ax; b128 = adx; c128 = ay; d128 = ady;
        step_x = (a128 * d128) < (c128 * b128);
      end
      if (step_x) begin
        ax += w;
        cx += sx;
        if (cx < 0 || cx >= ncol) break;
      end else begin
        if (sy == 0) break;
        ay += h;
        cy += sy;
        if (cy < 0 || cy >= nrow) break;
      end
    end
    cell_q[cell_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    cell_t e;
    if (rst) begin
      ox_r <= 0; oy_r <= 0; w_r <= 32'd65536; h_r <= 32'd65536;
      ncol_r <= 6'd32; nrow_r <= 6'd32;
      fails <= 0; segs_seen <= 0; cells_seen <= 0;
      cell_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ORIGIN_X: ox_r <= pwdata;
          REG_ORIGIN_Y: oy_r <= pwdata;
          REG_WIDTH:    w_r <= pwdata;
          REG_HEIGHT:   h_r <= pwdata;
          REG_COLUMNS:  ncol_r <= pwdata[5:0];
          REG_ROWS:     nrow_r <= pwdata[5:0];
          default: ;
        endcase
      end
      if (cell_valid && cell_ready) begin
        cells_seen <= cells_seen + 1;
        if (cell_q.size() == 0) begin
          $error("cell item with nothing expected: column %0d row %0d", column, row);
          fails <= fails + 1;
        end else begin
          e = cell_q.pop_front();
          if (column !== e.column || row !== e.row || cell_index !== e.cell_index ||
              last !== e.last) begin
            fails <= fails + 1;
            if (column !== e.column)
              $error("column expected %0d actual %0d", e.column, column);
            if (row !== e.row)
              $error("row expected %0d actual %0d", e.row, row);
            if (cell_index !== e.cell_index)
              $error("cell_index expected %0d actual %0d", e.cell_index, cell_index);
            if (last !== e.last)
              $error("last expected %0d actual %0d", e.last, last);
          end
        end
      end
      if (seg_valid && seg_ready) begin
        segs_seen <= segs_seen + 1;
        plan_walk(start_x, start_y, end_x, end_y);
      end
    end
    pending = cell_q.size();
  end

endmodule

[bench/segment_grid_cell_walker_test.sv]
`timescale 1ns / 100ps

module segment_grid_cell_walker_test;
  import sgw_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic seg_valid = 1'b0;
  logic seg_ready;
  logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic cell_valid;
  logic cell_ready = 1'b0;
  logic [4:0] column, row;
  logic [9:0] cell_index;
  logic last;

  int fails, pending, segs_seen, cells_seen;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_left = 0;
  bit hold_go = 1'b0, hold_done = 1'b0;
  int quiet = 0;
  int settings = 0;

  logic signed [31:0] ox_t = 0, oy_t = 0;
  logic [31:0] w_t = 32'd65536, h_t = 32'd65536;
  int ncol_t = 32, nrow_t = 32;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_grid_cell_walker DUT (.*);

  segment_grid_cell_walker_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst) begin
      cell_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      cell_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      cell_ready <= 1'b0;
    end else begin
      cell_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (seg_valid && seg_ready) || (cell_valid && cell_ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input logic signed [31:0] ox, oy, input logic [31:0] w, h,
                          input logic [5:0] nc, nr);
    drain();
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_COLUMNS, {26'd0, nc});
    reg_write(REG_ROWS, {26'd0, nr});
    ox_t = ox; oy_t = oy;
    w_t = (w == 0) ? 32'd1 : w;
    h_t = (h == 0) ? 32'd1 : h;
    ncol_t = (nc == 0) ? 1 : (nc > 32) ? 32 : nc;
    nrow_t = (nr == 0) ? 1 : (nr > 32) ? 32 : nr;
    settings++;
  endtask

  task automatic send_seg(input logic signed [31:0] x1, y1, x2, y2);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_valid <= 1'b0;
      @(posedge clk);
    end
    seg_valid <= 1'b1;
    start_x <= x1; start_y <= y1; end_x <= x2; end_y <= y2;
    @(negedge clk);
    while (!seg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(logic signed [31:0] org, logic [31:0] sz, int n);
    longint span, v;
    span = longint'(sz) * n;
    v = longint'(org) - span / 8 + longint'($urandom_range(0, 1000)) * (span + span / 4) / 1000;
    return v[31:0];
  endfunction

  task automatic random_phase(input int count);
    logic [31:0] x1, y1, x2, y2;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) begin
        x1 = pick_coord(ox_t, w_t, ncol_t);
        y1 = pick_coord(oy_t, h_t, nrow_t);
        x2 = pick_coord(ox_t, w_t, ncol_t);
        y2 = pick_coord(oy_t, h_t, nrow_t);
        if ($urandom_range(9) == 0) y2 = y1;
        else if ($urandom_range(9) == 0) x2 = x1;
      end else begin
        x1 = $urandom; y1 = $urandom; x2 = $urandom; y2 = $urandom;
      end
      send_seg(x1, y1, x2, y2);
    end
    seg_valid <= 1'b0;
  endtask

  task automatic random_grid();
    logic [31:0] w, h;
    logic [5:0] nc, nr;
    w = $urandom_range(99) < 80 ? $urandom_range(32'h1000, 32'h30000) : $urandom;
    h = $urandom_range(99) < 80 ? $urandom_range(32'h1000, 32'h30000) : $urandom;
    nc = $urandom_range(99) < 85 ? 6'($urandom_range(1, 32)) : 6'($urandom);
    nr = $urandom_range(99) < 85 ? 6'($urandom_range(1, 32)) : 6'($urandom);
    set_grid($signed($urandom_range(0, 32'h40000)) - 32'sh20000,
             $signed($urandom_range(0, 32'h40000)) - 32'sh20000, w, h, nc, nr);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unit cells, 32 by 32, origin at zero
    send_seg(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_seg(32'h0000_8000, 32'h0003_8000, 32'h0009_8000, 32'h0003_8000);
    send_seg(32'h0002_8000, 32'h0009_8000, 32'h0002_8000, 32'h0000_8000);
    send_seg(32'h0000_8000, 32'h0000_8000, 32'h0005_8000, 32'h0005_8000);
    send_seg(32'h0006_4000, 32'h0007_C000, 32'h0001_1000, 32'h0002_2000);
    send_seg(32'h0001_0000, 32'h0001_0000, 32'h0028_0000, 32'h0003_0000);
    send_seg(32'h001F_8000, 32'h0000_8000, 32'h0028_0000, 32'h0028_0000);
    send_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_seg(32'h0000_0000, 32'h001F_FFFF, 32'h001F_FFFF, 32'h0000_0000);
    send_seg(32'hFFFF_0000, 32'h0010_0000, 32'h0020_0000, 32'h0010_0000);
    send_seg(32'h0003_0000, 32'h0001_0000, 32'h0007_0000, 32'h0009_0000);
    seg_valid <= 1'b0;

    // zero and extreme cell sizes and out of range counts
    set_grid(32'sh8000_0000, 32'sh7FFF_FFFF, 32'd0, 32'd0, 6'd0, 6'd63);
    send_seg(32'h8000_0010, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0005, 32'h8000_0000);
    seg_valid <= 1'b0;
    set_grid(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 32'd1, 6'd63, 6'd0);
    send_seg(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0020);
    send_seg(32'h7FFF_FFFF, 32'h8000_0040, 32'h8000_0000, 32'h8000_0000);
    seg_valid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      random_grid();
      send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 69 : 28) : 0;
      stall_pct = (p == 2) ? 69 : (p == 3) ? 28 : 0;
      if (p == 0) hold_go = 1'b1;
      random_phase(23);
    end

    drain();
    $display("walked %0d segments into %0d cells across %0d grid settings",
             segs_seen, cells_seen, settings + 1);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
